// ===== src/bsa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bitmap slot allocator: field widths, command and status codes,
// and the default sizes used by the top level. Depends on nothing else.

package bsa_pkg;

    // Field widths of the request, the result and the slot count register.
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;

    // Default sizes of the bitmap.
    localparam int DEF_MAX_SLOTS  = 4096;
    localparam int DEF_WORD_WIDTH = 32;

    // Number of per-word full flags examined in one search cycle.
    localparam int SCAN_GROUP = 8;

    // Slot count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_USED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FREE  = 3'd4;

endpackage

// ===== src/bsa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the slot allocator: one for requests and
// one for results. Depends on bsa_pkg for the field widths.

interface bsa_req_if
    import bsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

interface bsa_rsp_if
    import bsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic                slot_used;

    modport source (output valid, output status, output granted_index, output slot_used,
                    input ready);
    modport sink   (input valid, input status, input granted_index, input slot_used,
                    output ready);
endinterface

// ===== src/bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// First-fit bitmap slot allocator, top level. Depends on bsa_pkg and on the
// channel interfaces in bsa_if.sv.

// The block keeps one bit per slot in a word memory with one write port and one
// registered read port, plus one full flag per word in flip-flops. After reset it
// runs a clearing pass of one word a cycle (MAX_SLOTS / WORD_WIDTH words rounded
// up, 128 at the defaults) and takes no request until it is done; the slot count
// register may be written meanwhile. It then handles one request at a time. Mark,
// unmark and query go from acceptance to the next acceptance through an index
// split by a reciprocal multiply, a memory read, the update and the result load.
// One whose index is out of range skips the read and the update. Allocate examines
// one group of eight full flags a cycle (one to sixteen groups at the defaults)
// before the chosen word is read and its lowest free bit taken. An allocate that
// finds every counted word full skips the read. A finished result waits in the
// output register, and the next request is accepted while it does; if that request
// finishes before the waiting result is taken, the block holds until it is.

module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)(
    input  logic               clk,
    input  logic               rst_n,
    bsa_req_if.sink            req,
    bsa_rsp_if.source          rsp,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    // Derived sizes.
    localparam int NUM_WORDS  = (MAX_SLOTS + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_WIDTH);
    localparam int GSEL_W     = $clog2(SCAN_GROUP);
    localparam int NUM_GROUPS = (NUM_WORDS + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int FLAG_BITS  = NUM_GROUPS * SCAN_GROUP;
    localparam int SPAN       = SCAN_GROUP * WORD_WIDTH;
    localparam int SW_RAW     = $clog2(FLAG_BITS * WORD_WIDTH + 1) + 1;
    localparam int SW         = (SW_RAW > COUNT_W + 1) ? SW_RAW : COUNT_W + 1;

    // Exact division of a slot index by WORD_WIDTH through a rounded-up reciprocal.
    localparam int DIV_SHIFT = IDX_W + BIT_W;
    localparam int RECIP_W   = IDX_W + 2;
    localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int PROD_W    = IDX_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_BITS,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [WIDX_W-1:0]     word_reg, word_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [GIDX_W-1:0]     group_reg, group_next;
    logic [SW-1:0]         gbase_reg, gbase_next;
    logic [SW-1:0]         wslot_reg, wslot_next;
    logic [WIDX_W-1:0]     clr_ptr_reg, clr_ptr_next;
    logic [FLAG_BITS-1:0]  full_reg, full_next;
    logic [COUNT_W-1:0]    slot_count_reg, slot_count_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]      res_granted_reg, res_granted_next;
    logic                  res_used_reg, res_used_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [IDX_W-1:0]      out_granted_reg, out_granted_next;
    logic                  out_used_reg, out_used_next;

    logic [WORD_WIDTH-1:0] mem [NUM_WORDS];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  wr_en;
    logic [WIDX_W-1:0]     wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    logic [SW-1:0]         count_ext;
    logic [SW-1:0]         live_count;
    logic [SCAN_GROUP-1:0] grp_elig;
    logic [GSEL_W-1:0]     grp_pick;
    logic                  grp_last;
    logic [SW-1:0]         bit_limit;
    logic [WORD_WIDTH-1:0] free_elig;
    logic [BIT_W-1:0]      free_pick;
    logic [WORD_WIDTH-1:0] bit_mask;
    logic [WORD_WIDTH-1:0] alloc_word;
    logic                  is_set;
    logic [PROD_W-1:0]     div_prod;
    logic                  in_range;

    // Effective slot count, saturated to the size of the bitmap.
    always_comb
    begin
        count_ext  = SW'(slot_count_reg);
        live_count = (count_ext > SW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : count_ext;
    end

    // Search step over one group of full flags: lowest word that is not full and
    // starts below the slot count.
    always_comb
    begin
        grp_pick = '0;
        for (int j = 0; j < SCAN_GROUP; j++)
        begin
            grp_elig[j] = !full_reg[{group_reg, GSEL_W'(j)}] &&
                          ((gbase_reg + SW'(j * WORD_WIDTH)) < live_count);
        end
        for (int j = SCAN_GROUP - 1; j >= 0; j--)
        begin
            if (grp_elig[j])
            begin
                grp_pick = GSEL_W'(j);
            end
        end
        grp_last = ((gbase_reg + SW'(SPAN)) >= live_count) ||
                   (group_reg == GIDX_W'(NUM_GROUPS - 1));
    end

    // Lowest free bit of the word just read that still lies below the slot count.
    always_comb
    begin
        bit_limit = live_count - wslot_reg;
        free_pick = '0;
        for (int b = 0; b < WORD_WIDTH; b++)
        begin
            free_elig[b] = !rd_data_reg[b] && (SW'(b) < bit_limit);
        end
        for (int b = WORD_WIDTH - 1; b >= 0; b--)
        begin
            if (free_elig[b])
            begin
                free_pick = BIT_W'(b);
            end
        end
        alloc_word = rd_data_reg | (WORD_WIDTH'(1) << free_pick);
    end

    // Index split and range check for the indexed commands.
    always_comb
    begin
        div_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
        in_range = SW'(idx_reg) < live_count;
        bit_mask = WORD_WIDTH'(1) << bit_reg;
        is_set   = rd_data_reg[bit_reg];
    end

    // Sequencer and result registers.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        word_next        = word_reg;
        bit_next         = bit_reg;
        group_next       = group_reg;
        gbase_next       = gbase_reg;
        wslot_next       = wslot_reg;
        clr_ptr_next     = clr_ptr_reg;
        full_next        = full_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_used_next    = res_used_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_used_next    = out_used_reg;
        wr_en            = 1'b0;
        wr_addr          = word_reg;
        wr_data          = rd_data_reg;

        slot_count_next = cfg_wr_en ? cfg_wr_data : slot_count_reg;

        // The output register empties when the result is taken.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_ptr_reg;
                wr_data = '0;
                if (clr_ptr_reg == WIDX_W'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + WIDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    idx_next   = req.slot_index;
                    group_next = '0;
                    gbase_next = '0;
                    state_next = (req.command == CMD_ALLOC) ? ST_SCAN : ST_DIV;
                end
            end

            ST_DIV:
            begin
                word_next = WIDX_W'(div_prod >> DIV_SHIFT);
                if (in_range)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    res_status_next  = STATUS_RANGE;
                    res_granted_next = '0;
                    res_used_next    = 1'b0;
                    state_next       = ST_RESP;
                end
            end

            ST_READ:
            begin
                // The memory presents word_reg at the next edge.
                bit_next   = BIT_W'(SW'(idx_reg) - SW'(word_reg) * SW'(WORD_WIDTH));
                state_next = (cmd_reg == CMD_ALLOC) ? ST_BITS : ST_EXEC;
            end

            ST_EXEC:
            begin
                res_status_next  = STATUS_OK;
                res_granted_next = '0;
                res_used_next    = 1'b0;
                case (cmd_reg)
                    CMD_MARK:
                    begin
                        if (is_set)
                        begin
                            res_status_next = STATUS_USED;
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            wr_data             = rd_data_reg | bit_mask;
                            full_next[word_reg] = &(rd_data_reg | bit_mask);
                        end
                    end
                    CMD_UNMARK:
                    begin
                        if (!is_set)
                        begin
                            res_status_next = STATUS_FREE;
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            wr_data             = rd_data_reg & ~bit_mask;
                            full_next[word_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_used_next = is_set;
                    end
                endcase
                state_next = ST_RESP;
            end

            ST_SCAN:
            begin
                if (|grp_elig)
                begin
                    word_next  = WIDX_W'({group_reg, grp_pick});
                    wslot_next = gbase_reg + SW'(grp_pick) * SW'(WORD_WIDTH);
                    state_next = ST_READ;
                end
                else if (grp_last)
                begin
                    res_status_next  = STATUS_FULL;
                    res_granted_next = '0;
                    res_used_next    = 1'b0;
                    state_next       = ST_RESP;
                end
                else
                begin
                    group_next = group_reg + GIDX_W'(1);
                    gbase_next = gbase_reg + SW'(SPAN);
                end
            end

            ST_BITS:
            begin
                res_used_next = 1'b0;
                if (|free_elig)
                begin
                    wr_en               = 1'b1;
                    wr_data             = alloc_word;
                    full_next[word_reg] = &alloc_word;
                    res_status_next     = STATUS_OK;
                    res_granted_next    = IDX_W'(wslot_reg + SW'(free_pick));
                end
                else
                begin
                    // Only the last, partly counted word can run out of bits.
                    res_status_next  = STATUS_FULL;
                    res_granted_next = '0;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    out_used_next    = res_used_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_ptr_reg    <= '0;
            full_reg       <= '0;
            slot_count_reg <= COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            full_reg       <= full_next;
            slot_count_reg <= slot_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        idx_reg         <= idx_next;
        word_reg        <= word_next;
        bit_reg         <= bit_next;
        group_reg       <= group_next;
        gbase_reg       <= gbase_next;
        wslot_reg       <= wslot_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_used_reg    <= res_used_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_used_reg    <= out_used_next;
    end

    // Bitmap word memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[word_reg];
    end

    // Channel outputs.
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_index = out_granted_reg;
    assign rsp.slot_used     = out_used_reg;

endmodule

// ===== tb/bsa_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the bitmap slot allocator: watches the request, result and slot
// count write traffic, keeps its own bitmap and compares every result as it leaves.
// Depends on bsa_pkg and on the channel interfaces in src/bsa_if.sv.

module bsa_checker
    import bsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    bsa_req_if                 req_mon,
    bsa_rsp_if                 rsp_mon,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    output int                 failures,
    output int                 pending,
    output int                 checked
);

    localparam int NUM_WORDS = (DEF_MAX_SLOTS + DEF_WORD_WIDTH - 1) / DEF_WORD_WIDTH;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic                slot_used;
    } alloc_result_t;

    // Our copy of the usage bitmap and of the slot count register.
    logic [DEF_WORD_WIDTH-1:0] usage_map [NUM_WORDS];
    logic [COUNT_W-1:0]        slot_limit;
    alloc_result_t             awaited_results [$];
    alloc_result_t             oldest;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        failures++;
    endtask

    // Applies one request to the bitmap and returns the result it should produce.
    function automatic alloc_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [IDX_W-1:0] idx);
        alloc_result_t res;
        int            live;
        int            s;
        int            word;
        int            bitpos;

        res        = '0;
        res.status = STATUS_OK;
        live       = (int'(slot_limit) > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : int'(slot_limit);

        if (cmd == CMD_ALLOC)
        begin
            // First fit: the lowest clear bit below the live count.
            res.status = STATUS_FULL;
            for (s = 0; s < live; s++)
            begin
                if (!usage_map[s / DEF_WORD_WIDTH][s % DEF_WORD_WIDTH])
                begin
                    usage_map[s / DEF_WORD_WIDTH][s % DEF_WORD_WIDTH] = 1'b1;
                    res.status        = STATUS_OK;
                    res.granted_index = IDX_W'(s);
                    break;
                end
            end
        end
        else if (int'(idx) >= live)
        begin
            res.status = STATUS_RANGE;
        end
        else
        begin
            word   = int'(idx) / DEF_WORD_WIDTH;
            bitpos = int'(idx) % DEF_WORD_WIDTH;
            case (cmd)
                CMD_MARK:
                begin
                    if (usage_map[word][bitpos])
                        res.status = STATUS_USED;
                    else
                        usage_map[word][bitpos] = 1'b1;
                end
                CMD_UNMARK:
                begin
                    if (!usage_map[word][bitpos])
                        res.status = STATUS_FREE;
                    else
                        usage_map[word][bitpos] = 1'b0;
                end
                default:
                begin
                    res.slot_used = usage_map[word][bitpos];
                end
            endcase
        end
        return res;
    endfunction

    // Results are checked before the request of the same edge is predicted, since
    // a result can never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
                usage_map[w] = '0;
            slot_limit = COUNT_RESET;
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                slot_limit = cfg_wr_data;

            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding",
                                    int'(rsp_mon.status), 0);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    checked++;
                    if (rsp_mon.status !== oldest.status)
                        report_mismatch("status", int'(rsp_mon.status), int'(oldest.status));
                    if (rsp_mon.granted_index !== oldest.granted_index)
                        report_mismatch("granted_index", int'(rsp_mon.granted_index),
                                        int'(oldest.granted_index));
                    if (rsp_mon.slot_used !== oldest.slot_used)
                        report_mismatch("slot_used", int'(rsp_mon.slot_used),
                                        int'(oldest.slot_used));
                end
            end

            if (req_mon.valid && req_mon.ready)
                awaited_results.push_back(apply_request(req_mon.command, req_mon.slot_index));

            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the bitmap slot allocator: clock, reset, request and slot count
// stimulus, result back-pressure, watchdog and verdict. Depends on bsa_pkg, the
// channel interfaces, the allocator RTL and the checker in tb/bsa_checker.sv.

module tb_top;
    import bsa_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int NUM_PHASES  = 8;
    localparam int PAUSE_PHASE = 6;
    localparam int LOW_WINDOW  = 64;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               calm        = 1'b0;

    int failures;
    int pending;
    int checked;
    int requests_sent    = 0;
    int settings_written = 0;
    int idle_cycles      = 0;

    // Slot count, request count and share of allocations in each random phase.
    // The last phase draws its count at random.
    int phase_count     [NUM_PHASES] = '{8191, 40, 1, 33, 264, 0, 4096, 0};
    int phase_items     [NUM_PHASES] = '{30, 30, 20, 30, 255, 15, 30, 25};
    int phase_alloc_pct [NUM_PHASES] = '{30, 35, 40, 35, 95, 30, 30, 30};

    bsa_req_if req_if ();
    bsa_rsp_if rsp_if ();

    bitmap_slot_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bsa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_if),
        .rsp_mon     (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .failures    (failures),
        .pending     (pending),
        .checked     (checked)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls in about one cycle in five, except in the calm phase.
    always @(negedge clk)
    begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    // Watchdog: ends the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no request, result or register write for %0d cycles",
                     IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request, with random idle cycles ahead of it, and returns at the
    // falling edge after it is taken. Valid stays high for a following request.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.slot_index <= idx;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic await_results();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Writes the slot count once the allocator has gone idle.
    task automatic write_slot_count(input logic [COUNT_W-1:0] value);
        await_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        settings_written++;
    endtask

    initial
    begin
        int                 p;
        int                 n;
        int                 count;
        int                 effective;
        int                 low_span;
        int                 near;
        int                 directed_sent;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;

        req_if.valid      = 1'b0;
        req_if.command    = CMD_ALLOC;
        req_if.slot_index = '0;
        rsp_if.ready      = 1'b0;

        // Hold reset, then release it; the clearing pass after it is waited out by the
        // handshake on the first request.
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests under the reset count of 4096: free and used slots,
        // double mark, double free, the top slot and first-fit grants.
        send_request(CMD_QUERY, 12'd0);
        send_request(CMD_UNMARK, 12'd0);
        send_request(CMD_MARK, 12'd0);
        send_request(CMD_MARK, 12'd0);
        send_request(CMD_QUERY, 12'd0);
        send_request(CMD_ALLOC, 12'd4095);
        send_request(CMD_MARK, 12'd4095);
        send_request(CMD_QUERY, 12'd4095);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_UNMARK, 12'd0);
        send_request(CMD_ALLOC, 12'd0);

        // A count of zero manages nothing: no grant and every index out of range.
        write_slot_count(13'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_MARK, 12'd0);
        send_request(CMD_QUERY, 12'd4095);
        send_request(CMD_UNMARK, 12'd0);

        // A single slot, already taken: full, then freed and granted again.
        write_slot_count(13'd1);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_QUERY, 12'd1);
        send_request(CMD_UNMARK, 12'd0);
        send_request(CMD_ALLOC, 12'd0);

        // A count above the maximum saturates, and the top slot kept its mark
        // while it was out of reach.
        write_slot_count(13'd8191);
        send_request(CMD_QUERY, 12'd4095);
        send_request(CMD_UNMARK, 12'd4095);
        send_request(CMD_QUERY, 12'd4095);
        directed_sent = requests_sent;

        // Random phases, one slot count each. Half the indexes fall in the low slots where
        // grants land, a quarter around the count limit and a quarter anywhere.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            count = (p == NUM_PHASES - 1) ? $urandom_range(2, DEF_MAX_SLOTS - 1)
                                          : phase_count[p];
            write_slot_count(COUNT_W'(count));
            calm <= (p == 0);
            effective = (count > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : count;
            low_span  = (effective < 1) ? 1 : ((effective > LOW_WINDOW) ? LOW_WINDOW : effective);

            for (n = 0; n < phase_items[p]; n++)
            begin
                // Halfway through one phase the sender holds off until all is back.
                if (p == PAUSE_PHASE && n == phase_items[p] / 2)
                begin
                    await_results();
                    repeat (12) @(negedge clk);
                end

                if ($urandom_range(0, 99) < phase_alloc_pct[p])
                begin
                    cmd = CMD_ALLOC;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_MARK;
                        1:       cmd = CMD_UNMARK;
                        default: cmd = CMD_QUERY;
                    endcase
                end

                case ($urandom_range(0, 3))
                    0:
                    begin
                        near = effective - 2 + $urandom_range(0, 3);
                        near = (near < 0) ? 0 : ((near > DEF_MAX_SLOTS - 1) ? DEF_MAX_SLOTS - 1
                                                                             : near);
                        idx  = IDX_W'(near);
                    end
                    1:       idx = IDX_W'($urandom);
                    default: idx = IDX_W'($urandom_range(0, low_span - 1));
                endcase

                send_request(cmd, idx);
            end
        end

        // Drain, then keep the clock running for anything unexpected to show up.
        await_results();
        repeat (20) @(negedge clk);

        $display("Summary: %0d requests (%0d directed), %0d count writes, %0d checked.",
                 requests_sent, directed_sent, settings_written, checked);
        $display("Summary: counts 0 to 8191, pool exhaustion, out of range, double mark and free.");
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
